### hw/rtl/owtr_pkg.sv
// Shared types, codes and constants of the multichannel 1-Wire temperature reader.
package owtr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESET1   = 3'd1,
    PH_CONVERT  = 3'd2,
    PH_WAIT     = 3'd3,
    PH_RESET2   = 3'd4,
    PH_READCMD  = 3'd5,
    PH_READDATA = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    FL_IDLE,
    FL_F1,
    FL_F2,
    FL_F3
  } flow_t;

  localparam logic       KIND_BUS    = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;

  localparam logic [1:0] DRV_LEAVE   = 2'd0;
  localparam logic [1:0] DRV_LOW     = 2'd1;
  localparam logic [1:0] DRV_RELEASE = 2'd2;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_NOPRES   = 2'd2;

  localparam logic [1:0] UK_RANGE    = 2'd0;
  localparam logic [1:0] UK_GLITCH   = 2'd1;
  localparam logic [1:0] UK_DIRECT   = 2'd2;
  localparam logic [1:0] UK_SMOOTH   = 2'd3;

  localparam logic       OP_START    = 1'b0;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_START_CONV = 8'h44;
  localparam logic [7:0] CMD_READ_SP    = 8'hBE;

  localparam logic [13:0] T_START    = 14'd20;
  localparam logic [13:0] T_RESET    = 14'd500;
  localparam logic [13:0] T_PRES     = 14'd40;
  localparam logic [13:0] T_PRES_END = 14'd460;
  localparam logic [13:0] T_SHORT    = 14'd5;
  localparam logic [13:0] T_SLOT     = 14'd60;
  localparam logic [13:0] T_CONV     = 14'd10000;
  localparam logic [13:0] T_READ_END = 14'd55;

  localparam int          OUT_DW     = 40;
  localparam logic [23:0] RECIP_100  = 24'd10737419;
  localparam int          RECIP_SH   = 30;
  localparam logic [23:0] NUM_OFFSET = 24'd4000050;
  localparam logic [15:0] Q_OFFSET   = 16'd40000;

  typedef struct packed {
    logic        load_bus;
    logic [1:0]  drive;
    logic [13:0] timer;
    logic [1:0]  status;
    logic        bus_last;
    logic        sample;
    logic [3:0]  bit_idx;
    logic [7:0]  levels;
    logic [3:0]  n_active;
    logic        filt_load;
    logic        filt_mult;
    logic        filt_commit;
    logic [2:0]  ch;
    logic        rep_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

### hw/rtl/owtr_dp.sv
// Datapath: raw readings, per-channel filter state, filter arithmetic and output register.
module owtr_dp #(
  parameter int CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  owtr_pkg::ctrl_cmd_t      cmd,
  output owtr_pkg::dp_status_t     sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [owtr_pkg::OUT_DW-1:0] out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  localparam int LANES = (CHANNELS < 8) ? CHANNELS : 8;

  logic [15:0] raw_r  [LANES];
  logic [15:0] filt_r [LANES];
  logic [LANES-1:0] pres_r;

  logic        out_valid_r;
  logic [owtr_pkg::OUT_DW-1:0] out_data_r;
  logic        out_kind_r, out_last_r;

  logic [1:0]  kind_r;
  logic [15:0] t_r;
  logic [23:0] x_r;
  logic [47:0] prod_r;

  // Stage one of the filter.
  logic signed [15:0] raw_s, f_s;
  logic signed [20:0] t_w, dt_w, adt_w;
  logic signed [24:0] num_w;
  logic [1:0]  kind_w;
  logic [15:0] q_w, newval_w;

  always_comb begin
    raw_s = $signed(raw_r[cmd.ch]);
    f_s   = $signed(filt_r[cmd.ch]);
    t_w   = 21'(raw_s) <<< 4;
    dt_w  = 21'(f_s) - t_w;
    adt_w = dt_w[20] ? -dt_w : dt_w;
    num_w = 25'(t_w) * 25'sd5 + 25'(f_s) * 25'sd95;
    if (raw_s < -16'sd480 || raw_s > 16'sd1280) begin
      kind_w = owtr_pkg::UK_RANGE;
    end else if (pres_r[cmd.ch]) begin
      if (raw_s == -16'sd1 && adt_w > 21'sd256) kind_w = owtr_pkg::UK_GLITCH;
      else if (adt_w < 21'sd768) kind_w = owtr_pkg::UK_DIRECT;
      else kind_w = owtr_pkg::UK_SMOOTH;
    end else if (raw_s > -16'sd480) begin
      kind_w = owtr_pkg::UK_DIRECT;
    end else begin
      kind_w = owtr_pkg::UK_RANGE;
    end
    // Floor of the offset numerator over 100, then the offset taken back out.
    q_w = 16'(prod_r >> owtr_pkg::RECIP_SH) - owtr_pkg::Q_OFFSET;
    case (kind_r)
      owtr_pkg::UK_DIRECT: newval_w = t_r;
      owtr_pkg::UK_SMOOTH: newval_w = q_w;
      default:             newval_w = filt_r[cmd.ch];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.filt_load) begin
      kind_r <= kind_w;
      t_r    <= t_w[15:0];
      x_r    <= 24'(num_w) + owtr_pkg::NUM_OFFSET;
    end
    if (cmd.filt_mult) prod_r <= 48'(x_r) * 48'(owtr_pkg::RECIP_100);
    if (cmd.sample) begin
      for (int i = 0; i < LANES; i++) begin
        if (4'(i) < cmd.n_active) raw_r[i][cmd.bit_idx] <= cmd.levels[i];
      end
    end
    if (cmd.load_bus) begin
      out_data_r <= {2'b00, 1'b0, 16'h0000, 3'b000, cmd.status, cmd.timer, cmd.drive};
      out_kind_r <= owtr_pkg::KIND_BUS;
      out_last_r <= cmd.bus_last;
    end else if (cmd.filt_commit) begin
      out_data_r <= {kind_r, pres_r[cmd.ch] | (kind_r == owtr_pkg::UK_DIRECT), newval_w,
                     cmd.ch, owtr_pkg::ST_BUSY, 14'd0, owtr_pkg::DRV_LEAVE};
      out_kind_r <= owtr_pkg::KIND_REPORT;
      out_last_r <= cmd.rep_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) filt_r[i] <= 16'h0000;
    end else begin
      if (cmd.filt_commit) begin
        filt_r[cmd.ch] <= newval_w;
        if (kind_r == owtr_pkg::UK_DIRECT) pres_r[cmd.ch] <= 1'b1;
      end
      if (cmd.load_bus || cmd.filt_commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_kind_r;
  assign out_tlast    = out_last_r;

endmodule

### hw/rtl/owtr_ctrl.sv
// Controller: bus sequencer for the 1-Wire phases and report flow state machine.
module owtr_ctrl #(
  parameter int CHANNELS   = 8,
  parameter int READ_BITS  = 40,
  parameter int POLL_LIMIT = 80
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 cfg_valid,
  input  logic [3:0]           cfg_data,
  input  owtr_pkg::dp_status_t sts,
  output owtr_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] LANES = 4'((CHANNELS < 8) ? CHANNELS : 8);

  owtr_pkg::phase_t phase_r, phase_nxt;
  owtr_pkg::flow_t  flow_r, flow_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [6:0] bc_r, bc_nxt, bc_inc;
  logic [3:0] act_r;
  logic [2:0] ch_r, ch_nxt;
  logic [3:0] n_w;
  logic [7:0] mask_w;
  logic       all_high, accept, cbit, fin;
  logic       filt_load_w, filt_mult_w, filt_commit_w;
  logic [15:0] cmd_word;

  always_comb begin
    n_w = (act_r > LANES) ? LANES : act_r;
    for (int i = 0; i < 8; i++) mask_w[i] = 4'(i) < n_w;
    all_high = (in_tdata & mask_w) == mask_w;
    cmd_word = {(phase_r == owtr_pkg::PH_CONVERT) ? owtr_pkg::CMD_START_CONV
                                                  : owtr_pkg::CMD_READ_SP,
                owtr_pkg::CMD_SKIP_ROM};
    cbit   = cmd_word[bc_r[3:0]];
    bc_inc = bc_r + 7'd1;
  end

  assign accept = in_tvalid && in_tready;

  // Bus sequencer.
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    bc_nxt    = bc_r;
    fin       = 1'b0;
    cmd       = '0;
    cmd.levels      = in_tdata;
    cmd.n_active    = n_w;
    cmd.bit_idx     = bc_r[3:0];
    cmd.ch          = ch_r;
    cmd.rep_last    = ({1'b0, ch_r} == n_w - 4'd1);
    cmd.filt_load   = filt_load_w;
    cmd.filt_mult   = filt_mult_w;
    cmd.filt_commit = filt_commit_w;
    if (accept) begin
      cmd.load_bus = 1'b1;
      if (in_tuser == owtr_pkg::OP_START) begin
        if (phase_r == owtr_pkg::PH_IDLE && n_w != 4'd0) begin
          bc_nxt    = '0;
          phase_nxt = owtr_pkg::PH_RESET1;
          sub_nxt   = '0;
          cmd.timer = owtr_pkg::T_START;
        end
      end else begin
        unique case (phase_r)
          owtr_pkg::PH_RESET1: begin
            if (sub_r == 2'd0) begin
              sub_nxt = 2'd1; cmd.drive = owtr_pkg::DRV_LOW; cmd.timer = owtr_pkg::T_RESET;
            end else if (sub_r == 2'd1) begin
              sub_nxt = 2'd2; cmd.drive = owtr_pkg::DRV_RELEASE; cmd.timer = owtr_pkg::T_PRES;
            end else begin
              sub_nxt = '0;
              if (all_high) begin
                phase_nxt  = owtr_pkg::PH_IDLE;
                cmd.status = owtr_pkg::ST_NOPRES;
              end else begin
                phase_nxt = owtr_pkg::PH_CONVERT;
                bc_nxt    = '0;
                cmd.timer = owtr_pkg::T_PRES_END;
              end
            end
          end
          owtr_pkg::PH_CONVERT, owtr_pkg::PH_READCMD: begin
            if (sub_r == 2'd0) begin
              cmd.drive = owtr_pkg::DRV_LOW;
              if (cbit) begin
                cmd.timer = owtr_pkg::T_SHORT; sub_nxt = 2'd1;
              end else begin
                cmd.timer = owtr_pkg::T_SLOT; sub_nxt = 2'd2;
              end
            end else begin
              cmd.timer = (sub_r == 2'd1) ? owtr_pkg::T_SLOT : owtr_pkg::T_SHORT;
              sub_nxt   = '0;
              cmd.drive = owtr_pkg::DRV_RELEASE;
              bc_nxt    = bc_inc;
              if (bc_inc == 7'd16) begin
                phase_nxt = (phase_r == owtr_pkg::PH_CONVERT) ? owtr_pkg::PH_WAIT
                                                              : owtr_pkg::PH_READDATA;
                bc_nxt    = '0;
              end
            end
          end
          owtr_pkg::PH_WAIT: begin
            if (sub_r == 2'd0) begin
              sub_nxt = 2'd1; cmd.drive = owtr_pkg::DRV_RELEASE; cmd.timer = owtr_pkg::T_CONV;
            end else if (sub_r == 2'd1) begin
              sub_nxt = 2'd2; cmd.drive = owtr_pkg::DRV_LOW; cmd.timer = owtr_pkg::T_SHORT;
            end else if (sub_r == 2'd2) begin
              sub_nxt = 2'd3; cmd.drive = owtr_pkg::DRV_RELEASE; cmd.timer = owtr_pkg::T_SHORT;
            end else begin
              sub_nxt   = '0;
              cmd.timer = owtr_pkg::T_SHORT;
              // A line still held low means a sensor is still converting.
              if (!all_high && bc_inc < 7'(POLL_LIMIT)) begin
                bc_nxt = bc_inc;
              end else begin
                bc_nxt    = '0;
                phase_nxt = owtr_pkg::PH_RESET2;
              end
            end
          end
          owtr_pkg::PH_RESET2: begin
            if (sub_r == 2'd0) begin
              sub_nxt = 2'd1; cmd.drive = owtr_pkg::DRV_LOW; cmd.timer = owtr_pkg::T_RESET;
            end else begin
              sub_nxt   = '0;
              phase_nxt = owtr_pkg::PH_READCMD;
              bc_nxt    = '0;
              cmd.drive = owtr_pkg::DRV_RELEASE;
              cmd.timer = owtr_pkg::T_RESET;
            end
          end
          owtr_pkg::PH_READDATA: begin
            if (sub_r == 2'd0) begin
              sub_nxt = 2'd1; cmd.drive = owtr_pkg::DRV_LOW; cmd.timer = owtr_pkg::T_SHORT;
            end else if (sub_r == 2'd1) begin
              sub_nxt = 2'd2; cmd.drive = owtr_pkg::DRV_RELEASE; cmd.timer = owtr_pkg::T_SHORT;
            end else if (sub_r == 2'd2) begin
              sub_nxt    = 2'd3;
              cmd.sample = (bc_r < 7'd16);
              cmd.timer  = owtr_pkg::T_READ_END;
            end else begin
              sub_nxt = '0;
              if (bc_inc >= 7'(READ_BITS)) begin
                phase_nxt  = owtr_pkg::PH_IDLE;
                bc_nxt     = '0;
                cmd.status = owtr_pkg::ST_DONE;
                fin        = 1'b1;
              end else begin
                bc_nxt    = bc_inc;
                cmd.timer = owtr_pkg::T_SHORT;
              end
            end
          end
          default: phase_nxt = owtr_pkg::PH_IDLE;
        endcase
      end
      cmd.bus_last = !(fin && n_w != 4'd0);
    end
  end

  // Report flow: one channel at a time through the three filter steps.
  always_comb begin
    flow_nxt      = flow_r;
    ch_nxt        = ch_r;
    in_tready     = 1'b0;
    filt_load_w   = 1'b0;
    filt_mult_w   = 1'b0;
    filt_commit_w = 1'b0;
    unique case (flow_r)
      owtr_pkg::FL_IDLE: begin
        in_tready = !sts.out_full;
        if (accept && fin && n_w != 4'd0) begin
          flow_nxt = owtr_pkg::FL_F1;
          ch_nxt   = '0;
        end
      end
      owtr_pkg::FL_F1: begin
        filt_load_w = 1'b1;
        flow_nxt = owtr_pkg::FL_F2;
      end
      owtr_pkg::FL_F2: begin
        filt_mult_w = 1'b1;
        flow_nxt = owtr_pkg::FL_F3;
      end
      owtr_pkg::FL_F3: begin
        if (!sts.out_full) begin
          filt_commit_w = 1'b1;
          ch_nxt   = ch_r + 3'd1;
          flow_nxt = cmd.rep_last ? owtr_pkg::FL_IDLE : owtr_pkg::FL_F1;
        end
      end
      default: flow_nxt = owtr_pkg::FL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owtr_pkg::PH_IDLE;
      flow_r  <= owtr_pkg::FL_IDLE;
      sub_r   <= '0;
      bc_r    <= '0;
      act_r   <= '0;
      ch_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      flow_r  <= flow_nxt;
      sub_r   <= sub_nxt;
      bc_r    <= bc_nxt;
      ch_r    <= ch_nxt;
      if (cfg_valid) act_r <= cfg_data;
    end
  end

  a_no_accept_in_reports: assert property (@(posedge clk) disable iff (!rst_n)
    flow_r != owtr_pkg::FL_IDLE |-> !accept)
    else $error("input word taken while reports are pending");
  a_done_starts_reports: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fin && n_w != 4'd0 |=> flow_r == owtr_pkg::FL_F1 && ch_r == 3'd0)
    else $error("finished read did not start the report sequence");
  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.filt_commit |-> !sts.out_full && {1'b0, ch_r} < n_w)
    else $error("report committed into a full output or past the active lines");

endmodule

### hw/rtl/onewire_multichannel_temp_reader.sv
// Top level of the multichannel 1-Wire temperature reader.
// Usage: the in_ channel carries events. in_tuser is the opcode (0 = start a
// measurement, 1 = one-shot timer expired) and in_tdata the sampled line levels.
// Each event yields one bus word on the out_ channel (out_tuser = 0) with the
// drive action, the next timer delay and a status. When the last read slot
// finishes, that bus word is followed by one temperature report per active
// line (out_tuser = 1), in line order; out_tlast marks the final word of an event.
// The cfg_ channel sets the number of active lines; write it only while idle.
// Timing: the bus word of an event is registered and ready in the cycle after
// the event is taken; the output register must empty before the next event is
// taken. Each report passes through three filter steps (load, reciprocal
// multiply, commit), and the commit waits while the output register is full;
// after a finished read, the next event is taken only once the last report has
// left the output register.
// Reset clears the sequencer, the filter state and the output register.
// When the receiver stalls, the pending word holds and input stays blocked.
module onewire_multichannel_temp_reader #(
  parameter int CHANNELS   = 8,
  parameter int READ_BITS  = 40,
  parameter int POLL_LIMIT = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // line_levels[7:0]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_action[1:0], timer_us[15:2], status[17:16], channel[20:18],
  // temperature[36:21], temp_valid[37], update_kind[39:38]
  output logic [39:0] out_tdata,
  output logic        out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // active_channels
);

  owtr_pkg::ctrl_cmd_t  cmd;
  owtr_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  owtr_ctrl #(
    .CHANNELS   (CHANNELS),
    .READ_BITS  (READ_BITS),
    .POLL_LIMIT (POLL_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  owtr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
